// ----- rtl/rtm_pkg.sv -----
// ----------------------------------------------------------------------------
// rtm_pkg
// Shared types and codes of the recursive ticket mutex: request kinds,
// result codes, register indexes, controller states and the bundles that
// pass between the controller, the datapath and the output buffer.
// ----------------------------------------------------------------------------
package rtm_pkg;

  localparam int KIND_W     = 3;
  localparam int OWNER_ID_W = 16;
  localparam int STATUS_W   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int NEST_W     = 8;

  typedef enum logic [KIND_W-1:0] {
    K_LOCK       = 3'd0,
    K_TRY_LOCK   = 3'd1,
    K_UNLOCK     = 3'd2,
    K_DESTROY    = 3'd3,
    K_OWNER_EXIT = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED        = 4'd0,
    ST_RELEASED        = 4'd1,
    ST_ALREADY_OWNED   = 4'd2,
    ST_RECURSION_LIMIT = 4'd3,
    ST_WOULD_BLOCK     = 4'd4,
    ST_NOT_OWNER       = 4'd5,
    ST_DESTROYED       = 4'd6,
    ST_QUEUE_FULL      = 4'd7,
    ST_QUEUED          = 4'd8,
    ST_BUSY            = 4'd9,
    ST_OK              = 4'd10,
    ST_EXIT_VIOLATION  = 4'd11
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECURSIVE_MODE = 2'd0,
    CFG_MAX_RECURSION  = 2'd1
  } cfg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

  typedef struct packed {
    status_t                 status;
    logic [OWNER_ID_W-1:0]   owner;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dp_result_t;

endpackage

// ----- rtl/rtm_req_if.sv -----
// ----------------------------------------------------------------------------
// rtm_req_if
// Request channel: one lock operation and the owner that issues it.
// ----------------------------------------------------------------------------
interface rtm_req_if
  import rtm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [KIND_W-1:0]     kind;
  logic [OWNER_ID_W-1:0] owner_id;

  modport source (output valid, output kind, output owner_id, input ready);
  modport sink   (input valid, input kind, input owner_id, output ready);
endinterface

// ----- rtl/rtm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// rtm_rsp_if
// Result channel: status code, the owner it concerns and the last flag.
// ----------------------------------------------------------------------------
interface rtm_rsp_if
  import rtm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [OWNER_ID_W-1:0] subject_owner;
  logic                  last;

  modport source (output valid, output status, output subject_owner, output last,
                  input ready);
  modport sink   (input valid, input status, input subject_owner, input last,
                  output ready);
endinterface

// ----- rtl/rtm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rtm_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rtm_cfg_if
  import rtm_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rtm_ctrl.sv -----
// ----------------------------------------------------------------------------
// rtm_ctrl
// Request sequencer: takes an item into the datapath, then runs it once the
// output buffer has room for its results.
// ----------------------------------------------------------------------------
module rtm_ctrl
  import rtm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  logic      out_empty,
  output ctrl_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_empty) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        cmd.exec = out_empty;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/rtm_dp.sv -----
// ----------------------------------------------------------------------------
// rtm_dp
// Lock datapath: holder, nesting count, destroyed flag, waiter fifo and
// configuration registers; decides the results of one request.
// ----------------------------------------------------------------------------
module rtm_dp
  import rtm_pkg::*;
#(
  parameter int WAIT_DEPTH = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             cmd,
  input  logic [KIND_W-1:0]     req_kind,
  input  logic [OWNER_ID_W-1:0] req_owner_id,
  rtm_cfg_if.sink               cfg,
  output dp_result_t            res
);

  localparam int OB    = (OWNER_BITS < OWNER_ID_W) ? OWNER_BITS : OWNER_ID_W;
  localparam int PTR_W = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int CNT_W = $clog2(WAIT_DEPTH + 1);

  // captured request
  logic [KIND_W-1:0] kind;
  logic [OB-1:0]     owner;

  logic              recursive_mode;
  logic [NEST_W-1:0] max_recursion;

  logic              held;
  logic              held_next;
  logic [OB-1:0]     holder;
  logic [OB-1:0]     holder_next;
  logic [NEST_W-1:0] nesting;
  logic [NEST_W-1:0] nesting_next;
  logic              dead;
  logic              dead_next;
  logic [PTR_W-1:0]  fifo_head;
  logic [PTR_W-1:0]  fifo_head_next;
  logic [PTR_W-1:0]  fifo_tail;
  logic [PTR_W-1:0]  fifo_tail_next;
  logic [CNT_W-1:0]  fifo_count;
  logic [CNT_W-1:0]  fifo_count_next;

  logic [OB-1:0]     wait_fifo [WAIT_DEPTH];
  logic [OB-1:0]     head_data;
  logic              push;

  logic              is_holder;
  logic              fifo_empty;
  logic              fifo_full;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  tail_inc;

  assign cfg.ready = 1'b1;

  assign is_holder  = held && (holder == owner);
  assign fifo_empty = (fifo_count == '0);
  assign fifo_full  = (fifo_count == CNT_W'(WAIT_DEPTH));
  assign head_inc   = (fifo_head == PTR_W'(WAIT_DEPTH - 1)) ? '0 : fifo_head + 1'b1;
  assign tail_inc   = (fifo_tail == PTR_W'(WAIT_DEPTH - 1)) ? '0 : fifo_tail + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind  <= req_kind;
      owner <= req_owner_id[OB-1:0];
    end
  end

  // waiter storage; head entry is read every cycle and the pointer only moves
  // during execution, so the registered copy is current when it is needed
  always_ff @(posedge clk) begin
    if (push) begin
      wait_fifo[fifo_tail] <= owner;
    end
    head_data <= wait_fifo[fifo_head];
  end

  always_comb begin
    held_next       = held;
    holder_next     = holder;
    nesting_next    = nesting;
    dead_next       = dead;
    fifo_head_next  = fifo_head;
    fifo_tail_next  = fifo_tail;
    fifo_count_next = fifo_count;
    push            = 1'b0;
    res.count         = 2'd1;
    res.first.status  = ST_OK;
    res.first.owner   = OWNER_ID_W'(owner);
    res.second.status = ST_ACQUIRED;
    res.second.owner  = OWNER_ID_W'(head_data);

    if (kind > KIND_W'(K_OWNER_EXIT)) begin
      res.count = 2'd0;
    end else if (dead) begin
      res.first.status = ST_DESTROYED;
    end else begin
      case (kind_t'(kind))
        K_LOCK, K_TRY_LOCK: begin
          if (is_holder) begin
            if (!recursive_mode) begin
              res.first.status = ST_ALREADY_OWNED;
            end else if (nesting >= max_recursion) begin
              res.first.status = ST_RECURSION_LIMIT;
            end else begin
              nesting_next     = nesting + 1'b1;
              res.first.status = ST_ACQUIRED;
            end
          end else if (!held && fifo_empty) begin
            held_next        = 1'b1;
            holder_next      = owner;
            nesting_next     = NEST_W'(1);
            res.first.status = ST_ACQUIRED;
          end else if (kind_t'(kind) == K_TRY_LOCK) begin
            res.first.status = ST_WOULD_BLOCK;
          end else if (fifo_full) begin
            res.first.status = ST_QUEUE_FULL;
          end else begin
            push             = cmd.exec;
            fifo_tail_next   = tail_inc;
            fifo_count_next  = fifo_count + 1'b1;
            res.first.status = ST_QUEUED;
          end
        end
        K_UNLOCK: begin
          if (!is_holder) begin
            res.first.status = ST_NOT_OWNER;
          end else if (nesting > NEST_W'(1)) begin
            nesting_next     = nesting - 1'b1;
            res.first.status = ST_RELEASED;
          end else if (!fifo_empty) begin
            // hand straight to the oldest waiter
            fifo_head_next   = head_inc;
            fifo_count_next  = fifo_count - 1'b1;
            holder_next      = head_data;
            nesting_next     = NEST_W'(1);
            res.count        = 2'd2;
            res.first.status = ST_RELEASED;
          end else begin
            held_next        = 1'b0;
            holder_next      = '0;
            nesting_next     = '0;
            res.first.status = ST_RELEASED;
          end
        end
        K_DESTROY: begin
          if (held || !fifo_empty) begin
            res.first.status = ST_BUSY;
          end else begin
            dead_next        = 1'b1;
            res.first.status = ST_OK;
          end
        end
        K_OWNER_EXIT: begin
          res.first.status = is_holder ? ST_EXIT_VIOLATION : ST_OK;
        end
        default: res.count = 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      recursive_mode <= 1'b1;
      max_recursion  <= '1;
      held           <= 1'b0;
      holder         <= '0;
      nesting        <= '0;
      dead           <= 1'b0;
      fifo_head      <= '0;
      fifo_tail      <= '0;
      fifo_count     <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg_idx_t'(cfg.index))
          CFG_RECURSIVE_MODE: recursive_mode <= cfg.data[0];
          CFG_MAX_RECURSION:  max_recursion  <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.exec) begin
        held       <= held_next;
        holder     <= holder_next;
        nesting    <= nesting_next;
        dead       <= dead_next;
        fifo_head  <= fifo_head_next;
        fifo_tail  <= fifo_tail_next;
        fifo_count <= fifo_count_next;
      end
    end
  end

endmodule

// ----- rtl/rtm_outbuf.sv -----
// ----------------------------------------------------------------------------
// rtm_outbuf
// Two-entry result buffer that drives the result channel; loaded with all
// results of one request at once and drained one item per handshake.
// ----------------------------------------------------------------------------
module rtm_outbuf
  import rtm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  dp_result_t res,
  output logic       out_empty,
  rtm_rsp_if.source  rsp
);

  logic [1:0] count;
  result_t    entry0;
  result_t    entry1;
  logic       pop;

  assign pop       = rsp.valid && rsp.ready;
  assign out_empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= res.count;
    end else if (pop) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry0 <= res.first;
      entry1 <= res.second;
    end else if (pop) begin
      entry0 <= entry1;
    end
  end

  assign rsp.valid         = !out_empty;
  assign rsp.status        = entry0.status;
  assign rsp.subject_owner = entry0.owner;
  assign rsp.last          = (count == 2'd1);

endmodule

// ----- rtl/recursive_ticket_mutex_top.sv -----
// recursive ticket mutex: a taken request is captured, then executed into the result
// buffer, which shows its first result; no new request is taken while one executes,
// and a request whose result buffer is still busy waits in the execute step until it
// empties; a handoff unlock yields two result items back to back
// reset: lock free, not destroyed, waiter fifo empty, config at recursive / 255
// ----------------------------------------------------------------------------
// recursive_ticket_mutex_top
// Top level: sequencer, lock datapath and result buffer.
// ----------------------------------------------------------------------------
module recursive_ticket_mutex_top
  import rtm_pkg::*;
#(
  parameter int WAIT_DEPTH = 16,
  parameter int OWNER_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  rtm_req_if.sink   req,
  rtm_rsp_if.source rsp,
  rtm_cfg_if.sink   cfg
);

  ctrl_cmd_t  cmd;
  dp_result_t res;
  logic       out_empty;

  rtm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .out_empty (out_empty),
    .cmd       (cmd)
  );

  rtm_dp #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .OWNER_BITS (OWNER_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .req_kind     (req.kind),
    .req_owner_id (req.owner_id),
    .cfg          (cfg),
    .res          (res)
  );

  rtm_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load      (cmd.exec),
    .res       (res),
    .out_empty (out_empty),
    .rsp       (rsp)
  );

endmodule

// ----- rtl/rtm_checker.sv -----
// ----------------------------------------------------------------------------
// rtm_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rtm_checker
  import rtm_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input logic [STATUS_W-1:0]   rsp_status,
  input logic [OWNER_ID_W-1:0] rsp_subject_owner,
  input logic                  rsp_last
);

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_subject_owner) && $stable(rsp_last))
    else $error("result changed while stalled");

  // only a handoff release produces a non-final result
  a_first_is_release: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_last |-> rsp_status == ST_RELEASED)
    else $error("non-final result is not a release");

  // the handoff grant follows the release right away
  a_handoff_grant: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_ready && !rsp_last |=> rsp_valid && rsp_last
      && rsp_status == ST_ACQUIRED)
    else $error("handoff grant missing after release");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

endmodule

bind recursive_ticket_mutex_top rtm_checker u_rtm_checker (
  .clk               (clk),
  .rst               (rst),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_status        (rsp.status),
  .rsp_subject_owner (rsp.subject_owner),
  .rsp_last          (rsp.last)
);
